// ===== design/dda_pkg.sv =====
// Shared types and constants for the dial delta accumulator.
package dda_pkg;

    localparam int NUM_DIALS_DEF = 8;
    localparam int SAMPLE_W      = 16;
    localparam int CC_W          = 7;
    localparam int COUNT_W       = 8;

    localparam logic [CC_W-1:0]           BASE_RESET = 7'd102;
    localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 8'sd127;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN  = -8'sd127;

    // Item function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] dial_bits;
    } in_item_t;

    typedef struct packed {
        logic [CC_W-1:0] controller_number;
        logic [CC_W-1:0] magnitude;
        logic            last_of_burst;
    } out_item_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic sample_load;
        logic scan_start;
        logic emit;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic any_pending;
        logic cur_nonzero;
        logic more_above;
        logic slot_free;
    } dp_status_t;

endpackage

// ===== design/dda_ctrl.sv =====
// Controller state machine: sample update and tick scan sequencing.
module dda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_func,
    output logic                in_stall,
    input  dda_pkg::dp_status_t status,
    output dda_pkg::dp_cmd_t    cmd
);

    dda_pkg::state_t state_reg;
    dda_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            dda_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_func == dda_pkg::FUNC_TICK)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = dda_pkg::ST_SCAN;
                    end
                    else
                    begin
                        cmd.sample_load = 1'b1;
                    end
                end
            end
            dda_pkg::ST_SCAN:
            begin
                if (!status.any_pending)
                begin
                    state_next = dda_pkg::ST_IDLE;
                end
                else if (status.cur_nonzero)
                begin
                    // wait for the output slot, then report this dial
                    if (status.slot_free)
                    begin
                        cmd.emit = 1'b1;
                        if (!status.more_above)
                        begin
                            state_next = dda_pkg::ST_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = dda_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/dda_dp.sv =====
// Datapath: sample history, per-dial counters, scan index and output register.
module dda_dp #(
    parameter int NUM_DIALS = dda_pkg::NUM_DIALS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dda_pkg::SAMPLE_W-1:0]  dial_bits,
    input  logic                          cfg_write,
    input  logic [dda_pkg::CC_W-1:0]      cfg_data,
    input  dda_pkg::dp_cmd_t              cmd,
    output dda_pkg::dp_status_t           status,
    input  logic                          out_stall,
    output logic                          out_valid,
    output dda_pkg::out_item_t            out_data
);

    localparam int IDX_W = (NUM_DIALS > 1) ? $clog2(NUM_DIALS) : 1;

    logic [dda_pkg::SAMPLE_W-1:0]        prev_reg;
    logic signed [dda_pkg::COUNT_W-1:0]  counts_reg [NUM_DIALS];
    logic [IDX_W-1:0]                    idx_reg;
    logic [dda_pkg::CC_W-1:0]            base_reg;
    logic                                out_valid_reg;
    dda_pkg::out_item_t                  out_reg;

    logic [dda_pkg::SAMPLE_W-1:0]        diff;
    logic signed [dda_pkg::COUNT_W-1:0]  cur_count;
    logic [NUM_DIALS-1:0]                pend_mask;
    logic [NUM_DIALS-1:0]                above_mask;
    logic [dda_pkg::CC_W-1:0]            cc_sum;
    logic [dda_pkg::CC_W-1:0]            mag;
    logic                                pos;

    assign diff      = dial_bits ^ prev_reg;
    assign cur_count = counts_reg[idx_reg];
    assign pos       = ~cur_count[dda_pkg::COUNT_W-1];
    assign mag       = pos ? cur_count[dda_pkg::CC_W-1:0]
                           : dda_pkg::CC_W'(-cur_count);
    assign cc_sum    = base_reg + (dda_pkg::CC_W'(idx_reg) << 1)
                       + {{(dda_pkg::CC_W-1){1'b0}}, pos};

    always_comb
    begin
        for (int i = 0; i < NUM_DIALS; i++)
        begin
            pend_mask[i]  = (counts_reg[i] != '0) && (i >= int'(idx_reg));
            above_mask[i] = (counts_reg[i] != '0) && (i > int'(idx_reg));
        end
    end

    assign status.any_pending = |pend_mask;
    assign status.cur_nonzero = (cur_count != '0);
    assign status.more_above  = |above_mask;
    assign status.slot_free   = !out_valid_reg || !out_stall;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            idx_reg       <= '0;
            base_reg      <= dda_pkg::BASE_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_DIALS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                base_reg <= cfg_data;
            end
            if (cmd.sample_load)
            begin
                prev_reg <= dial_bits;
                for (int i = 0; i < NUM_DIALS; i++)
                begin
                    // up change wins; saturate symmetric at +/-127
                    if (diff[2*i] && counts_reg[i] != dda_pkg::COUNT_MAX)
                    begin
                        counts_reg[i] <= counts_reg[i] + 8'sd1;
                    end
                    else if (diff[2*i+1] && counts_reg[i] != dda_pkg::COUNT_MIN)
                    begin
                        counts_reg[i] <= counts_reg[i] - 8'sd1;
                    end
                end
            end
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
            end
            if (cmd.emit)
            begin
                counts_reg[idx_reg] <= '0;
            end
            if (cmd.emit || cmd.advance)
            begin
                idx_reg <= IDX_W'(idx_reg + 1'b1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.controller_number <= cc_sum;
            out_reg.magnitude         <= mag;
            out_reg.last_of_burst     <= !status.more_above;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/dial_delta_accumulator_cc_emitter_top.sv =====
// Top level of the dial delta accumulator with controller-change reports.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | in        | in_valid/in_stall   | in_item_t: func, dial_bits
//  out     | out       | out_valid/out_stall | out_item_t: cc, magnitude, last
//  cfg     | in        | cfg_valid/cfg_ready | base_controller (7 bits)
//
// A sample transfer updates all NUM_DIALS counters in parallel.
// A tick transfer starts a scan that visits one dial per cycle, except while
// out_stall holds the output register, and ends after the last nonzero dial.
// A tick with every counter at zero ends its scan without reports.
// in_stall is high during the scan; a sample or tick can be taken while the
// last report of a burst still waits in the output register.
// rst_n clears counters, sample history and base_controller (to 102).
// cfg_ready is always high.
module dial_delta_accumulator_cc_emitter_top #(
    parameter int NUM_DIALS = dda_pkg::NUM_DIALS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  dda_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output dda_pkg::out_item_t        out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [dda_pkg::CC_W-1:0]  cfg_data
);

    dda_pkg::dp_cmd_t    cmd;
    dda_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    dda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dda_dp #(
        .NUM_DIALS (NUM_DIALS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dial_bits (in_data.dial_bits),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ===== design/dda_checker.sv =====
// Port-level checker for the dial delta accumulator, bound to the top level.
module dda_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input dda_pkg::in_item_t   in_data,
    input logic                out_valid,
    input logic                out_stall,
    input dda_pkg::out_item_t  out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // reports never carry a zero magnitude
    a_mag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.magnitude != '0)
        else $error("zero magnitude reported");

    // while a non-final report is pending the scan is still running
    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_of_burst |-> in_stall)
        else $error("input taken in the middle of a burst");

    // a sample transfer never produces a report
    a_sample_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.func == dda_pkg::FUNC_SAMPLE
        |=> !$rose(out_valid))
        else $error("report after sample");

endmodule

bind dial_delta_accumulator_cc_emitter_top dda_checker u_dda_checker (.*);

// ===== bench/dial_report_checker.sv =====
// Report checker for the dial accumulator: predicts reports from channel transfers and compares.
module dial_report_checker #(
    parameter int NUM_DIALS = dda_pkg::NUM_DIALS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  dda_pkg::in_item_t        in_data,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  dda_pkg::out_item_t       out_data,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [dda_pkg::CC_W-1:0] cfg_data,
    output int                       mismatches,
    output int                       reports_due
);

    logic [dda_pkg::SAMPLE_W-1:0]       last_sample;
    logic signed [dda_pkg::COUNT_W-1:0] dial_count [NUM_DIALS];
    logic [dda_pkg::CC_W-1:0]           base_cc;
    dda_pkg::out_item_t                 due_reports [$];
    dda_pkg::out_item_t                 want;

    // Up wins when both sense bits flip; down only when up is absent or blocked at the top.
    function automatic void fold_sample(logic [dda_pkg::SAMPLE_W-1:0] sample);
        logic [dda_pkg::SAMPLE_W-1:0] flipped;
        flipped = sample ^ last_sample;
        for (int d = 0; d < NUM_DIALS; d++)
        begin
            if (flipped[2*d] && dial_count[d] < dda_pkg::COUNT_MAX)
                dial_count[d] = dial_count[d] + 8'sd1;
            else if (flipped[2*d+1] && dial_count[d] > dda_pkg::COUNT_MIN)
                dial_count[d] = dial_count[d] - 8'sd1;
        end
        last_sample = sample;
    endfunction

    // One report per nonzero dial, lowest dial first; the final one closes the burst.
    function automatic void drain_counts();
        dda_pkg::out_item_t                 rpt;
        logic signed [dda_pkg::COUNT_W-1:0] c;
        int                                 last_dial;
        last_dial = -1;
        for (int d = 0; d < NUM_DIALS; d++)
            if (dial_count[d] != 0)
                last_dial = d;
        for (int d = 0; d < NUM_DIALS; d++)
        begin
            c = dial_count[d];
            if (c != 0)
            begin
                // controller number wraps at 7 bits
                rpt.controller_number =
                    dda_pkg::CC_W'(int'(base_cc) + 2 * d + ((c > 0) ? 1 : 0));
                rpt.magnitude         = dda_pkg::CC_W'((c > 0) ? c : -c);
                rpt.last_of_burst     = (d == last_dial);
                due_reports.push_back(rpt);
                dial_count[d] = '0;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample = '0;
            for (int d = 0; d < NUM_DIALS; d++)
                dial_count[d] = '0;
            base_cc = dda_pkg::BASE_RESET;
            due_reports.delete();
            mismatches  = 0;
            reports_due = 0;
        end
        else
        begin
            // output first: a report leaving now belongs to an earlier tick
            if (out_valid && !out_stall)
            begin
                if (due_reports.size() == 0)
                begin
                    $display("%0t: unexpected report, actual cc %0d magnitude %0d last %0b",
                             $time, out_data.controller_number, out_data.magnitude,
                             out_data.last_of_burst);
                    mismatches++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("controller_number", 8'(want.controller_number),
                                8'(out_data.controller_number));
                    check_field("magnitude", 8'(want.magnitude), 8'(out_data.magnitude));
                    check_field("last_of_burst", 8'(want.last_of_burst),
                                8'(out_data.last_of_burst));
                end
            end
            if (cfg_valid && cfg_ready)
                base_cc = cfg_data;
            if (in_valid && !in_stall)
            begin
                if (in_data.func == dda_pkg::FUNC_TICK)
                    drain_counts();
                else
                    fold_sample(in_data.dial_bits);
            end
            reports_due = due_reports.size();
        end
    end

endmodule

// ===== bench/tb_dial_delta_accumulator_cc_emitter_top.sv =====
// Testbench top for the dial delta accumulator: stimulus, handshake idling and the verdict.
module tb_dial_delta_accumulator_cc_emitter_top;

    localparam int PERIOD       = 8;
    localparam int RESET_CYCLES = 12;
    // scan of a tick with no reports ends without walking the dials
    localparam int DRAIN_CYCLES = dda_pkg::NUM_DIALS_DEF + 8;
    localparam int LONG_HOLD    = 150;     // receiver hold-off used to back up the block
    localparam int STUCK_LIMIT  = 2000;    // cycles with no transfer on any channel
    localparam int PHASE_ITEMS  = 16;      // random items per configuration phase

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    dda_pkg::in_item_t        in_data;
    logic                     out_valid;
    logic                     out_stall;
    dda_pkg::out_item_t       out_data;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [dda_pkg::CC_W-1:0] cfg_data;

    int         mismatches;
    int         reports_due;

    // Stimulus-side state
    logic [dda_pkg::SAMPLE_W-1:0] sample_now;   // last sample offered, so rotations build on it
    int         items_sent;
    bit         in_idle_on;
    bit         out_idle_on;
    int         hold_req;                // bumped to request one long receiver hold-off

    dial_delta_accumulator_cc_emitter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Checker sits beside the block and sees every transfer on all three channels.
    dial_report_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    always #(PERIOD / 2) clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item and hold it until the transfer. Valid is left high on return:
    // the next call either keeps it up or drops it for a gap, one assignment per edge.
    task automatic send_item(input logic func, input logic [dda_pkg::SAMPLE_W-1:0] bits);
        dda_pkg::in_item_t item;
        int                gap;
        gap = (in_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            in_data  <= dda_pkg::in_item_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        item.func      = func;
        item.dial_bits = bits;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        if (func == dda_pkg::FUNC_SAMPLE)
            sample_now = bits;
        items_sent++;
    endtask

    // Sender goes quiet until every predicted report has left the block, then lets a
    // report-less scan finish so the block is truly idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (reports_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; only called with the block idle.
    task automatic write_base(input logic [dda_pkg::CC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Well-formed use: a dial pattern keeps rotating the same way for a while, with some
    // raw noise samples and stray ticks mixed in, and the burst closes with a tick.
    task automatic run_burst();
        logic [dda_pkg::SAMPLE_W-1:0] rotation;
        int                           len;
        int                           pick;
        rotation = dda_pkg::SAMPLE_W'($urandom);
        len      = $urandom_range(1, 10);
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(20, 40);
        repeat (len)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                send_item(dda_pkg::FUNC_SAMPLE, sample_now ^ rotation);
            else if (pick < 9)
                send_item(dda_pkg::FUNC_SAMPLE, dda_pkg::SAMPLE_W'($urandom));
            else
                send_item(dda_pkg::FUNC_TICK, dda_pkg::SAMPLE_W'($urandom));
        end
        send_item(dda_pkg::FUNC_TICK, dda_pkg::SAMPLE_W'($urandom));
    endtask

    task automatic random_phase();
        int first;
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS)
            run_burst();
    endtask

    // Receiver: random stalls, plus the long hold-off on request, counted here.
    initial
    begin : receiver
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != holds_done)
            begin
                holds_done = hold_req;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: too long without any transfer means the block hung.
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("** dial_delta_accumulator_cc_emitter_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        sample_now  = '0;
        items_sent  = 0;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        hold_req    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset base 102, no idling on either side.
        send_item(dda_pkg::FUNC_SAMPLE, 16'hFFFF);   // both bits of every dial flip: up wins
        send_item(dda_pkg::FUNC_SAMPLE, 16'hAAAA);   // even bits flip: all up again
        send_item(dda_pkg::FUNC_SAMPLE, 16'hAAAA);   // no change
        send_item(dda_pkg::FUNC_SAMPLE, 16'h0000);   // odd bits flip: all down one
        send_item(dda_pkg::FUNC_TICK,   16'h0000);   // full burst of eight reports
        send_item(dda_pkg::FUNC_TICK,   16'hFFFF);   // all counters clear: no reports
        send_item(dda_pkg::FUNC_SAMPLE, 16'h0002);   // dial 0 down
        send_item(dda_pkg::FUNC_SAMPLE, 16'h0000);   // dial 0 down again
        send_item(dda_pkg::FUNC_SAMPLE, 16'h8000);   // top dial down
        send_item(dda_pkg::FUNC_SAMPLE, 16'hC000);   // top dial up
        send_item(dda_pkg::FUNC_SAMPLE, 16'h4000);   // top dial down
        send_item(dda_pkg::FUNC_TICK,   16'hFFFF);   // negative reports; history stays 0x4000
        send_item(dda_pkg::FUNC_SAMPLE, 16'h0100);
        send_item(dda_pkg::FUNC_TICK,   16'h5A5A);
        send_item(dda_pkg::FUNC_SAMPLE, 16'h1234);
        send_item(dda_pkg::FUNC_SAMPLE, 16'hEDCB);
        send_item(dda_pkg::FUNC_TICK,   16'hA5A5);
        send_item(dda_pkg::FUNC_TICK,   16'h0000);
        wait_drained();

        // Base 0 with idling on both sides.
        write_base('0);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        random_phase();
        wait_drained();

        // Base 127: controller numbers wrap. The receiver holds off while the
        // sender keeps offering, so the block fills and stalls its input.
        write_base({dda_pkg::CC_W{1'b1}});
        in_idle_on  = 1'b0;
        out_idle_on = 1'b1;
        hold_req++;
        repeat (2) run_burst();
        random_phase();
        wait_drained();

        // Base 112, highest in normal use; receiver idles, sender runs flat out.
        write_base(dda_pkg::CC_W'(112));
        random_phase();
        wait_drained();

        // Random base; sender idles, receiver never stalls.
        write_base(dda_pkg::CC_W'($urandom));
        in_idle_on  = 1'b1;
        out_idle_on = 1'b0;
        random_phase();
        wait_drained();

        if (mismatches == 0 && reports_due == 0)
            $display("** dial_delta_accumulator_cc_emitter_top: PASSED **");
        else
            $display("** dial_delta_accumulator_cc_emitter_top: FAILED **");
        $finish;
    end

endmodule
